### sv/cfs_pkg.sv
// Shared types and constants for the Cholesky factor / solve block.
// Used by cfs_ctrl, cfs_dpath and cholesky_factor_solve; no dependencies.
package cfs_pkg;

    localparam int ACC_W      = 64;   // Q16.48 accumulator
    localparam int FRAC_BITS  = 24;   // fraction bits of a Q8.24 value
    localparam int IDX_W      = 5;    // row / column / solution index fields
    localparam int OP_W       = 3;
    localparam int ST_W       = 2;
    localparam int ORD_W      = 6;    // matrix_order register
    localparam int ADDR_MAX_W = 6;    // widest row/column address (order up to 64)

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_MAT   = 3'd0,
        OP_LOAD_RHS   = 3'd1,
        OP_FACTOR     = 3'd2,
        OP_SOLVE      = 3'd3,
        OP_SOLVE_UNIT = 3'd4
    } t_opcode;

    typedef enum logic [ST_W-1:0] {
        ST_OK           = 2'd0,
        ST_NOT_PD       = 2'd1,
        ST_NOT_FACTORED = 2'd2
    } t_status;

    // first operand source of a multiply-accumulate
    typedef enum logic [2:0] {
        ASEL_MAT  = 3'd0,
        ASEL_VEC  = 3'd1,
        ASEL_XS   = 3'd2,
        ASEL_ONE  = 3'd3,
        ASEL_ZERO = 3'd4
    } t_asel;

    // second operand source
    typedef enum logic {
        BSEL_MAT = 1'b0,
        BSEL_XS  = 1'b1
    } t_bsel;

    // controller -> datapath commands
    typedef struct packed {
        logic                  mac_v;
        logic                  mac_load;
        t_asel                 a_sel;
        t_bsel                 b_sel;
        logic [ADDR_MAX_W-1:0] a_row;
        logic [ADDR_MAX_W-1:0] a_col;
        logic [ADDR_MAX_W-1:0] b_row;
        logic [ADDR_MAX_W-1:0] b_col;
        logic [ADDR_MAX_W-1:0] xs_addr;
        logic [ADDR_MAX_W-1:0] i_addr;
        logic [ADDR_MAX_W-1:0] w_row;
        logic [ADDR_MAX_W-1:0] w_col;
        logic                  mat_we_load;
        logic                  vec_we_load;
        logic                  mat_we_fac;
        logic                  xs_we;
        logic                  piv_we;
        logic                  sq_start;
        logic                  div_start;
        logic                  div_diag;
        logic                  out_load;
        logic                  out_from_xs;
        logic [IDX_W-1:0]      out_idx;
        t_status               out_st;
        logic                  out_last;
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic acc_nonpos;
        logic sq_busy;
        logic div_busy;
        logic out_free;
    } t_stat;

endpackage

### sv/cfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for every store of the block.
module cfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/cfs_ctrl.sv
// Sequencer for load, factor and solve commands of the Cholesky block.
// Depends on cfs_pkg; drives cfs_dpath through t_cmd and reads t_stat.
module cfs_ctrl #(
    parameter int MAX_ORDER = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [cfs_pkg::OP_W-1:0]     i_opcode,
    input  logic [cfs_pkg::IDX_W-1:0]    i_row,
    input  logic [cfs_pkg::IDX_W-1:0]    i_col,
    input  logic                         i_cfg_wr_en,
    input  logic [cfs_pkg::ORD_W-1:0]    i_cfg_wr_data,
    input  cfs_pkg::t_stat               i_stat,
    output cfs_pkg::t_cmd                o_cmd
);

    localparam int CW = $clog2(MAX_ORDER + 1);
    localparam int AM = cfs_pkg::ADDR_MAX_W;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_MAC   = 10'b00_0000_0010,
        S_DRAIN = 10'b00_0000_0100,
        S_PIVOT = 10'b00_0000_1000,
        S_SQRT  = 10'b00_0001_0000,
        S_DIV   = 10'b00_0010_0000,
        S_DIVW  = 10'b00_0100_0000,
        S_RES   = 10'b00_1000_0000,
        S_EMRD  = 10'b01_0000_0000,
        S_EMIT  = 10'b10_0000_0000
    } t_state;

    // which inner product is being accumulated
    typedef enum logic [1:0] {
        K_FDIAG = 2'd0,
        K_FOFF  = 2'd1,
        K_FWD   = 2'd2,
        K_BWD   = 2'd3
    } t_kind;

    t_state                      r_state, n_state;
    t_kind                       r_kind, n_kind;
    logic [CW-1:0]               r_i, n_i;
    logic [CW-1:0]               r_j, n_j;
    logic [CW-1:0]               r_k, n_k;
    logic [CW-1:0]               r_order, n_order;
    logic                        r_first, n_first;
    logic                        r_unit, n_unit;
    logic [cfs_pkg::IDX_W-1:0]   r_col, n_col;
    logic                        r_factored, n_factored;
    logic                        r_dr, n_dr;
    logic [cfs_pkg::IDX_W-1:0]   r_res_idx, n_res_idx;
    cfs_pkg::t_status            r_res_st, n_res_st;

    logic [CW-1:0]               w_kend;
    logic                        w_i_last;
    logic                        w_unit_hit;
    logic                        w_row_ok;
    logic                        w_col_ok;

    assign w_kend     = (r_kind == K_BWD) ? r_order : r_i;
    assign w_i_last   = !((r_i + CW'(1)) < r_order);
    assign w_unit_hit = (32'(r_i) == 32'(r_col));
    assign w_row_ok   = (32'(i_row) < MAX_ORDER);
    assign w_col_ok   = (32'(i_col) < MAX_ORDER);
    assign o_s_tready = (r_state == S_IDLE);

    // next state and command decode
    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_order    = r_order;
        n_first    = r_first;
        n_unit     = r_unit;
        n_col      = r_col;
        n_factored = r_factored;
        n_dr       = r_dr;
        n_res_idx  = r_res_idx;
        n_res_st   = r_res_st;

        o_cmd         = '0;
        o_cmd.i_addr  = AM'(r_i);
        o_cmd.xs_addr = AM'(r_i);
        o_cmd.w_row   = AM'(r_j);
        o_cmd.w_col   = AM'(r_i);
        o_cmd.div_diag = (r_kind == K_FWD) || (r_kind == K_BWD);

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    unique case (cfs_pkg::t_opcode'(i_opcode))
                        cfs_pkg::OP_LOAD_MAT: begin
                            if (w_row_ok && w_col_ok) begin
                                o_cmd.mat_we_load = 1'b1;
                                n_factored        = 1'b0;
                            end
                        end
                        cfs_pkg::OP_LOAD_RHS: begin
                            o_cmd.vec_we_load = w_row_ok;
                        end
                        cfs_pkg::OP_FACTOR: begin
                            n_i     = '0;
                            n_k     = '0;
                            n_kind  = K_FDIAG;
                            n_first = 1'b1;
                            n_state = S_MAC;
                        end
                        cfs_pkg::OP_SOLVE, cfs_pkg::OP_SOLVE_UNIT: begin
                            if (!r_factored) begin
                                n_res_idx = '0;
                                n_res_st  = cfs_pkg::ST_NOT_FACTORED;
                                n_state   = S_RES;
                            end else begin
                                n_unit  = (cfs_pkg::t_opcode'(i_opcode) ==
                                           cfs_pkg::OP_SOLVE_UNIT);
                                n_col   = i_col;
                                n_i     = '0;
                                n_kind  = K_FWD;
                                n_first = 1'b1;
                                n_state = S_MAC;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // one multiply-accumulate issued per cycle
            S_MAC: begin
                if (r_first) begin
                    o_cmd.mac_v    = 1'b1;
                    o_cmd.mac_load = 1'b1;
                    n_first        = 1'b0;
                    n_k            = (r_kind == K_BWD) ? (r_i + CW'(1)) : '0;
                    case (r_kind)
                        K_FDIAG: begin
                            o_cmd.a_sel = cfs_pkg::ASEL_MAT;
                            o_cmd.a_row = AM'(r_i);
                            o_cmd.a_col = AM'(r_i);
                        end
                        K_FOFF: begin
                            o_cmd.a_sel = cfs_pkg::ASEL_MAT;
                            o_cmd.a_row = AM'(r_i);
                            o_cmd.a_col = AM'(r_j);
                        end
                        K_FWD: begin
                            if (r_unit) begin
                                o_cmd.a_sel = w_unit_hit ? cfs_pkg::ASEL_ONE
                                                         : cfs_pkg::ASEL_ZERO;
                            end else begin
                                o_cmd.a_sel = cfs_pkg::ASEL_VEC;
                            end
                        end
                        default: begin
                            o_cmd.a_sel = cfs_pkg::ASEL_XS;
                        end
                    endcase
                end else if (r_k < w_kend) begin
                    o_cmd.mac_v = 1'b1;
                    n_k         = r_k + CW'(1);
                    case (r_kind)
                        K_FDIAG: begin
                            o_cmd.a_sel = cfs_pkg::ASEL_MAT;
                            o_cmd.b_sel = cfs_pkg::BSEL_MAT;
                            o_cmd.a_row = AM'(r_i);
                            o_cmd.a_col = AM'(r_k);
                            o_cmd.b_row = AM'(r_i);
                            o_cmd.b_col = AM'(r_k);
                        end
                        K_FOFF: begin
                            o_cmd.a_sel = cfs_pkg::ASEL_MAT;
                            o_cmd.b_sel = cfs_pkg::BSEL_MAT;
                            o_cmd.a_row = AM'(r_i);
                            o_cmd.a_col = AM'(r_k);
                            o_cmd.b_row = AM'(r_j);
                            o_cmd.b_col = AM'(r_k);
                        end
                        K_FWD: begin
                            o_cmd.a_sel   = cfs_pkg::ASEL_MAT;
                            o_cmd.b_sel   = cfs_pkg::BSEL_XS;
                            o_cmd.a_row   = AM'(r_i);
                            o_cmd.a_col   = AM'(r_k);
                            o_cmd.xs_addr = AM'(r_k);
                        end
                        default: begin
                            o_cmd.a_sel   = cfs_pkg::ASEL_MAT;
                            o_cmd.b_sel   = cfs_pkg::BSEL_XS;
                            o_cmd.a_row   = AM'(r_k);
                            o_cmd.a_col   = AM'(r_i);
                            o_cmd.xs_addr = AM'(r_k);
                        end
                    endcase
                end else begin
                    n_dr    = 1'b0;
                    n_state = S_DRAIN;
                end
            end

            // let the two-stage MAC pipe settle into the accumulator
            S_DRAIN: begin
                n_dr = 1'b1;
                if (r_dr) begin
                    n_state = (r_kind == K_FDIAG) ? S_PIVOT : S_DIV;
                end
            end

            S_PIVOT: begin
                if (i_stat.acc_nonpos) begin
                    n_factored = 1'b0;
                    n_res_idx  = cfs_pkg::IDX_W'(r_i);
                    n_res_st   = cfs_pkg::ST_NOT_PD;
                    n_state    = S_RES;
                end else begin
                    o_cmd.sq_start = 1'b1;
                    n_state        = S_SQRT;
                end
            end

            S_SQRT: begin
                if (!i_stat.sq_busy) begin
                    o_cmd.piv_we = 1'b1;
                    if (w_i_last) begin
                        n_factored = 1'b1;
                        n_res_idx  = '0;
                        n_res_st   = cfs_pkg::ST_OK;
                        n_state    = S_RES;
                    end else begin
                        n_j     = r_i + CW'(1);
                        n_kind  = K_FOFF;
                        n_first = 1'b1;
                        n_state = S_MAC;
                    end
                end
            end

            S_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIVW;
            end

            S_DIVW: begin
                if (!i_stat.div_busy) begin
                    n_first = 1'b1;
                    n_state = S_MAC;
                    case (r_kind)
                        K_FOFF: begin
                            o_cmd.mat_we_fac = 1'b1;
                            if ((r_j + CW'(1)) < r_order) begin
                                n_j = r_j + CW'(1);
                            end else begin
                                n_i    = r_i + CW'(1);
                                n_kind = K_FDIAG;
                            end
                        end
                        K_FWD: begin
                            o_cmd.xs_we = 1'b1;
                            if (w_i_last) begin
                                n_kind = K_BWD;
                            end else begin
                                n_i = r_i + CW'(1);
                            end
                        end
                        default: begin
                            o_cmd.xs_we = 1'b1;
                            if (r_i == '0) begin
                                n_first = 1'b0;
                                n_state = S_EMRD;
                            end else begin
                                n_i = r_i - CW'(1);
                            end
                        end
                    endcase
                end
            end

            S_RES: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_idx  = r_res_idx;
                    o_cmd.out_st   = r_res_st;
                    o_cmd.out_last = 1'b1;
                    n_state        = S_IDLE;
                end
            end

            S_EMRD: begin
                n_state = S_EMIT;
            end

            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load    = 1'b1;
                    o_cmd.out_from_xs = 1'b1;
                    o_cmd.out_idx     = cfs_pkg::IDX_W'(r_i);
                    o_cmd.out_st      = cfs_pkg::ST_OK;
                    o_cmd.out_last    = w_i_last;
                    if (w_i_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_i     = r_i + CW'(1);
                        n_state = S_EMRD;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // order register write, clamped to 1..MAX_ORDER
        if (i_cfg_wr_en) begin
            n_factored = 1'b0;
            if (i_cfg_wr_data == '0) begin
                n_order = CW'(1);
            end else if (32'(i_cfg_wr_data) > MAX_ORDER) begin
                n_order = CW'(MAX_ORDER);
            end else begin
                n_order = CW'(i_cfg_wr_data);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_kind     <= K_FDIAG;
            r_i        <= '0;
            r_j        <= '0;
            r_k        <= '0;
            r_order    <= CW'(1);
            r_first    <= 1'b0;
            r_unit     <= 1'b0;
            r_col      <= '0;
            r_factored <= 1'b0;
            r_dr       <= 1'b0;
            r_res_idx  <= '0;
            r_res_st   <= cfs_pkg::ST_OK;
        end else begin
            r_state    <= n_state;
            r_kind     <= n_kind;
            r_i        <= n_i;
            r_j        <= n_j;
            r_k        <= n_k;
            r_order    <= n_order;
            r_first    <= n_first;
            r_unit     <= n_unit;
            r_col      <= n_col;
            r_factored <= n_factored;
            r_dr       <= n_dr;
            r_res_idx  <= n_res_idx;
            r_res_st   <= n_res_st;
        end
    end

endmodule

### sv/cfs_dpath.sv
// Datapath: matrix/vector stores, MAC pipe with saturating Q16.48 accumulator,
// bitwise square root, radix-2 divider and output register. Uses cfs_pkg, cfs_ram.
module cfs_dpath #(
    parameter int MAX_ORDER   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  cfs_pkg::t_cmd              i_cmd,
    output cfs_pkg::t_stat             o_stat,
    input  logic [cfs_pkg::IDX_W-1:0]  i_row,
    input  logic [cfs_pkg::IDX_W-1:0]  i_col,
    input  logic [VALUE_WIDTH-1:0]     i_value,
    input  logic                       i_m_tready,
    output logic                       o_m_tvalid,
    output logic [VALUE_WIDTH-1:0]     o_solution_value,
    output logic [cfs_pkg::IDX_W-1:0]  o_solution_index,
    output logic [cfs_pkg::ST_W-1:0]   o_status_code,
    output logic                       o_last_flag
);

    localparam int VW  = VALUE_WIDTH;
    localparam int AW  = $clog2(MAX_ORDER);
    localparam int MD  = 1 << (2 * AW);
    localparam int FB  = cfs_pkg::FRAC_BITS;
    localparam int PW  = (2 * VW > VW + FB) ? 2 * VW : VW + FB;
    localparam int XW  = ((PW > 64) ? PW : 64) + 1;

    localparam logic signed [XW-1:0] LIM_HI = $signed({{(XW-63){1'b0}}, {63{1'b1}}});
    localparam logic signed [XW-1:0] LIM_LO = $signed({{(XW-63){1'b1}}, {63{1'b0}}});
    localparam logic [63:0] MAX64  = {1'b0, {63{1'b1}}};
    localparam logic [63:0] MIN64  = {1'b1, {63{1'b0}}};
    localparam logic [63:0] VMAX64 = {{(65-VW){1'b0}}, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

    // ---------------- stores ----------------
    logic [VW-1:0] w_mat_a, w_mat_b, w_vec, w_xs, w_diag;
    logic          w_mat_we;
    logic [2*AW-1:0] w_mat_waddr;
    logic [VW-1:0] w_mat_wdata;
    logic [VW-1:0] w_quot;
    logic [VW-1:0] w_sq_piv;

    assign w_mat_we    = i_cmd.mat_we_load || i_cmd.mat_we_fac;
    assign w_mat_waddr = i_cmd.mat_we_load ? {AW'(i_row), AW'(i_col)}
                                           : {i_cmd.w_row[AW-1:0], i_cmd.w_col[AW-1:0]};
    assign w_mat_wdata = i_cmd.mat_we_load ? i_value : w_quot;

    // two copies of the matrix give two read ports
    cfs_ram #(.WIDTH(VW), .DEPTH(MD)) u_mat_a (
        .i_clk   (i_clk),
        .i_we    (w_mat_we),
        .i_waddr (w_mat_waddr),
        .i_wdata (w_mat_wdata),
        .i_raddr ({i_cmd.a_row[AW-1:0], i_cmd.a_col[AW-1:0]}),
        .o_rdata (w_mat_a)
    );

    cfs_ram #(.WIDTH(VW), .DEPTH(MD)) u_mat_b (
        .i_clk   (i_clk),
        .i_we    (w_mat_we),
        .i_waddr (w_mat_waddr),
        .i_wdata (w_mat_wdata),
        .i_raddr ({i_cmd.b_row[AW-1:0], i_cmd.b_col[AW-1:0]}),
        .o_rdata (w_mat_b)
    );

    cfs_ram #(.WIDTH(VW), .DEPTH(MAX_ORDER)) u_vec (
        .i_clk   (i_clk),
        .i_we    (i_cmd.vec_we_load),
        .i_waddr (AW'(i_row)),
        .i_wdata (i_value),
        .i_raddr (i_cmd.i_addr[AW-1:0]),
        .o_rdata (w_vec)
    );

    cfs_ram #(.WIDTH(VW), .DEPTH(MAX_ORDER)) u_xs (
        .i_clk   (i_clk),
        .i_we    (i_cmd.xs_we),
        .i_waddr (i_cmd.i_addr[AW-1:0]),
        .i_wdata (w_quot),
        .i_raddr (i_cmd.xs_addr[AW-1:0]),
        .o_rdata (w_xs)
    );

    cfs_ram #(.WIDTH(VW), .DEPTH(MAX_ORDER)) u_diag (
        .i_clk   (i_clk),
        .i_we    (i_cmd.piv_we),
        .i_waddr (i_cmd.i_addr[AW-1:0]),
        .i_wdata (w_sq_piv),
        .i_raddr (i_cmd.i_addr[AW-1:0]),
        .o_rdata (w_diag)
    );

    // ---------------- MAC pipe ----------------
    logic                 r_s1_v, r_s1_load;
    cfs_pkg::t_asel       r_s1_asel;
    cfs_pkg::t_bsel       r_s1_bsel;
    logic                 r_s2_v, r_s2_load;
    logic signed [63:0]   r_prod;
    logic signed [63:0]   r_acc;

    logic signed [VW-1:0] w_a, w_b;
    logic signed [XW-1:0] w_ext, w_shl, w_mul, w_one, w_wide;
    logic signed [63:0]   w_prod;
    logic [64:0]          w_diff;
    logic [63:0]          w_acc_sub;

    always_comb begin
        case (r_s1_asel)
            cfs_pkg::ASEL_MAT: w_a = w_mat_a;
            cfs_pkg::ASEL_VEC: w_a = w_vec;
            cfs_pkg::ASEL_XS:  w_a = w_xs;
            default:           w_a = '0;
        endcase
    end

    assign w_b     = (r_s1_bsel == cfs_pkg::BSEL_MAT) ? w_mat_b : w_xs;
    assign w_ext   = w_a;
    assign w_shl   = w_ext <<< FB;
    assign w_mul   = w_a * w_b;
    assign w_one   = $signed({{(XW-1){1'b0}}, 1'b1}) <<< (2 * FB);
    assign w_wide  = !r_s1_load ? w_mul :
                     (r_s1_asel == cfs_pkg::ASEL_ONE) ? w_one : w_shl;
    // saturate product to the accumulator range
    assign w_prod  = (w_wide > LIM_HI) ? MAX64 :
                     (w_wide < LIM_LO) ? MIN64 : w_wide[63:0];

    // saturating subtract from the accumulator
    assign w_diff    = {r_acc[63], r_acc} - {r_prod[63], r_prod};
    assign w_acc_sub = (w_diff[64] != w_diff[63]) ? (w_diff[64] ? MIN64 : MAX64)
                                                  : w_diff[63:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= i_cmd.mac_v;
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_load <= i_cmd.mac_load;
        r_s1_asel <= i_cmd.a_sel;
        r_s1_bsel <= i_cmd.b_sel;
        r_s2_load <= r_s1_load;
        r_prod    <= w_prod;
        if (r_s2_v) begin
            r_acc <= r_s2_load ? r_prod : w_acc_sub;
        end
    end

    // ---------------- square root, one result bit per cycle ----------------
    logic        r_sq_busy;
    logic [4:0]  r_sq_cnt;
    logic [63:0] r_sq_v, r_sq_res, r_sq_bit;
    logic [63:0] w_sq_t;
    logic        w_sq_ge;
    logic [VW-1:0] r_pivot;

    assign w_sq_t   = r_sq_res + r_sq_bit;
    assign w_sq_ge  = (r_sq_v >= w_sq_t);
    assign w_sq_piv = (r_sq_res > VMAX64) ? VMAX : r_sq_res[VW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_busy <= 1'b0;
        end else if (i_cmd.sq_start) begin
            r_sq_busy <= 1'b1;
        end else if (r_sq_busy && (r_sq_cnt == 5'd31)) begin
            r_sq_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_start) begin
            r_sq_v   <= r_acc;
            r_sq_res <= '0;
            r_sq_bit <= 64'd1 << 62;
            r_sq_cnt <= '0;
        end else if (r_sq_busy) begin
            r_sq_cnt <= r_sq_cnt + 5'd1;
            r_sq_bit <= r_sq_bit >> 2;
            if (w_sq_ge) begin
                r_sq_v   <= r_sq_v - w_sq_t;
                r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
            end else begin
                r_sq_res <= r_sq_res >> 1;
            end
        end
        if (i_cmd.piv_we) begin
            r_pivot <= w_sq_piv;
        end
    end

    // ---------------- restoring divider, one quotient bit per cycle ----------------
    logic          r_dv_busy, r_dv_neg, r_dv_zero;
    logic [5:0]    r_dv_cnt;
    logic [63:0]   r_dv_q;
    logic [VW-1:0] r_dv_rem, r_dv_d;
    logic [VW-1:0] w_dvsr;
    logic [VW-1:0] w_dv_t;
    logic          w_dv_ge;

    assign w_dvsr  = i_cmd.div_diag ? w_diag : r_pivot;
    assign w_dv_t  = {r_dv_rem[VW-2:0], r_dv_q[63]};
    assign w_dv_ge = (w_dv_t >= r_dv_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_busy <= 1'b0;
        end else if (i_cmd.div_start) begin
            r_dv_busy <= 1'b1;
        end else if (r_dv_busy && (r_dv_cnt == 6'd63)) begin
            r_dv_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dv_zero <= w_dvsr[VW-1] || (w_dvsr == '0);
            r_dv_d    <= w_dvsr;
            r_dv_neg  <= r_acc[63];
            r_dv_q    <= r_acc[63] ? (64'd0 - r_acc) : r_acc;
            r_dv_rem  <= '0;
            r_dv_cnt  <= '0;
        end else if (r_dv_busy) begin
            r_dv_cnt <= r_dv_cnt + 6'd1;
            r_dv_rem <= w_dv_ge ? (w_dv_t - r_dv_d) : w_dv_t;
            r_dv_q   <= {r_dv_q[62:0], w_dv_ge};
        end
    end

    // sign and saturate the quotient; zero for a zero or negative divisor
    always_comb begin
        if (r_dv_zero) begin
            w_quot = '0;
        end else if (!r_dv_neg) begin
            w_quot = (r_dv_q > VMAX64) ? VMAX : r_dv_q[VW-1:0];
        end else begin
            w_quot = (r_dv_q > (VMAX64 + 64'd1)) ? VMIN : (VW'(0) - r_dv_q[VW-1:0]);
        end
    end

    // ---------------- output register ----------------
    logic                      r_out_v;
    logic [VW-1:0]             r_out_val;
    logic [cfs_pkg::IDX_W-1:0] r_out_idx;
    cfs_pkg::t_status          r_out_st;
    logic                      r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_v <= 1'b1;
        end else if (i_m_tready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_val  <= i_cmd.out_from_xs ? w_xs : '0;
            r_out_idx  <= i_cmd.out_idx;
            r_out_st   <= i_cmd.out_st;
            r_out_last <= i_cmd.out_last;
        end
    end

    assign o_m_tvalid       = r_out_v;
    assign o_solution_value = r_out_val;
    assign o_solution_index = r_out_idx;
    assign o_status_code    = r_out_st;
    assign o_last_flag      = r_out_last;

    assign o_stat.acc_nonpos = r_acc[63] || (r_acc == '0);
    assign o_stat.sq_busy    = r_sq_busy;
    assign o_stat.div_busy   = r_dv_busy;
    assign o_stat.out_free   = !r_out_v || i_m_tready;

endmodule

### sv/cholesky_factor_solve.sv
// Cholesky factor and solve. Factor time is set by the single MAC pipe, the
// 32-step root and the 64-step radix-2 divider (one per off-diagonal entry).
// Solve uses two divisions per element, then emits the results by index.
// One command at a time. Synchronous active-low reset clears control state;
// matrix order resets to 1 and the factored flag to 0; stores are not cleared.
module cholesky_factor_solve #(
    parameter int MAX_ORDER   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // config: matrix_order
    input  logic                               i_cfg_wr_en,
    input  logic [cfs_pkg::ORD_W-1:0]          i_cfg_wr_data,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: row_index[4:0], column_index, entry_value, zero pad
    input  logic [((2*cfs_pkg::IDX_W+VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // tuser: opcode
    input  logic [cfs_pkg::OP_W-1:0]           s_axis_tuser,
    // output stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: solution_value, solution_index, zero pad
    output logic [((VALUE_WIDTH+cfs_pkg::IDX_W+7)/8)*8-1:0] m_axis_tdata,
    // tuser: status_code
    output logic [cfs_pkg::ST_W-1:0]           m_axis_tuser,
    output logic                               m_axis_tlast
);

    localparam int IW     = cfs_pkg::IDX_W;
    localparam int OUT_DW = ((VALUE_WIDTH + IW + 7) / 8) * 8;

    cfs_pkg::t_cmd    w_cmd;
    cfs_pkg::t_stat   w_stat;
    logic [IW-1:0]    w_row, w_col;
    logic [VALUE_WIDTH-1:0] w_value;
    logic [VALUE_WIDTH-1:0] w_sol_val;
    logic [IW-1:0]    w_sol_idx;

    assign w_row   = s_axis_tdata[IW-1:0];
    assign w_col   = s_axis_tdata[2*IW-1:IW];
    assign w_value = s_axis_tdata[2*IW+VALUE_WIDTH-1:2*IW];

    cfs_ctrl #(.MAX_ORDER(MAX_ORDER)) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_axis_tvalid),
        .o_s_tready    (s_axis_tready),
        .i_opcode      (s_axis_tuser),
        .i_row         (w_row),
        .i_col         (w_col),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_stat        (w_stat),
        .o_cmd         (w_cmd)
    );

    cfs_dpath #(.MAX_ORDER(MAX_ORDER), .VALUE_WIDTH(VALUE_WIDTH)) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_row            (w_row),
        .i_col            (w_col),
        .i_value          (w_value),
        .i_m_tready       (m_axis_tready),
        .o_m_tvalid       (m_axis_tvalid),
        .o_solution_value (w_sol_val),
        .o_solution_index (w_sol_idx),
        .o_status_code    (m_axis_tuser),
        .o_last_flag      (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_DW'({w_sol_idx, w_sol_val});

endmodule
